FILE: hw/rtl/vrt_pkg.sv
// ----------------------------------------------------------------------------
// vrt_pkg: shared definitions for the voxel ray traversal core
// Codes, default sizing and the divider result bundle.
// ----------------------------------------------------------------------------
package vrt_pkg;

    // Default number of fraction bits in ray distances (unsigned Q(32-F).F)
    localparam int DIST_FRAC_BITS_DEF = 16;

    // Input kind (tuser)
    localparam logic FUNC_START  = 1'b0;
    localparam logic FUNC_REPORT = 1'b1;

    // Class of a queried cell
    localparam logic [1:0] CLS_PASS = 2'd0;
    localparam logic [1:0] CLS_HIT  = 2'd1;

    // Result status (tuser)
    localparam logic [1:0] STATUS_QUERY   = 2'd0;
    localparam logic [1:0] STATUS_HIT     = 2'd1;
    localparam logic [1:0] STATUS_MISS    = 2'd2;
    localparam logic [1:0] STATUS_BLOCKED = 2'd3;

    // Register map: word index carried in paddr[2]
    localparam int          PADDR_W          = 3;
    localparam logic        REG_MAX_DISTANCE = 1'b0;
    localparam logic [15:0] MAX_DIST_RESET   = 16'd2048;

    // Step codes (signed 2 bits)
    localparam logic [1:0] STEP_NONE = 2'b00;
    localparam logic [1:0] STEP_POS  = 2'b01;
    localparam logic [1:0] STEP_NEG  = 2'b11;

    // Divider result handed back to the sequencer
    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } div_res_t;

endpackage

FILE: hw/rtl/vrt_div.sv
// ----------------------------------------------------------------------------
// vrt_div: restoring radix-2 divider, one quotient bit per cycle
// Unsigned DW-bit dividend by 16-bit divisor; quotient saturates to 32 bits when DW exceeds 32.
// ----------------------------------------------------------------------------
module vrt_div #(
    parameter int DW = vrt_pkg::DIST_FRAC_BITS_DEF + 15
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DW-1:0]     dividend,
    input  logic [15:0]       divisor,
    output vrt_pkg::div_res_t res
);

    localparam int CW = $clog2(DW + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0] dvd_reg, dvd_next;
    logic [DW-1:0] quo_reg, quo_next;
    logic [15:0]   rem_reg, rem_next;
    logic [15:0]   dsr_reg, dsr_next;

    logic [16:0]   rem_sh;
    logic [16:0]   rem_sub;
    logic          ge;

    assign rem_sh  = {rem_reg, dvd_reg[DW-1]};
    assign rem_sub = rem_sh - {1'b0, dsr_reg};
    assign ge      = rem_sh >= {1'b0, dsr_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CW'(DW);
            dvd_next  = dividend;
            quo_next  = '0;
            rem_next  = '0;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            // shift in the next dividend bit, subtract when it fits
            rem_next = ge ? rem_sub[15:0] : rem_sh[15:0];
            quo_next = {quo_reg[DW-2:0], ge};
            dvd_next = {dvd_reg[DW-2:0], 1'b0};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign res.done = done_reg;

    generate
        if (DW > 32) begin : g_sat
            assign res.quotient = (|quo_reg[DW-1:32]) ? '1 : quo_reg[31:0];
        end else begin : g_nosat
            assign res.quotient = 32'(quo_reg);
        end
    endgenerate

endmodule

FILE: hw/rtl/voxel_ray_traversal_core.sv
// ----------------------------------------------------------------------------
// voxel_ray_traversal_core: fixed-point 3D grid ray march
// Start a ray, then feed back the class of each queried cell until the ray
// hits, is blocked, or runs beyond max_distance.
// ----------------------------------------------------------------------------
// A start beat (tuser = 0) carries the origin (signed Q15.8) and direction
// (signed Q1.14). The core answers with a query beat for the origin cell once
// its per-axis step, first boundary distance and boundary spacing are known.
// These come from six divisions on one shared radix-2 divider, one quotient
// bit per cycle, while a start holds the input closed (a zero direction axis
// skips its two divisions). A report beat (tuser = 1) with class hit or block
// holds the input through accept and emit; a pass-through class holds it
// through accept, pick the nearest boundary, advance and emit, set by the
// three-way compare and the saturating boundary add that run one after the
// other. In every case the result beat turns valid as the input reopens; emit
// waits while the output register still holds an untaken beat. Input is taken
// only while the sequencer is idle; the output register holds a finished beat
// so the next input can be taken while it waits. A report with no ray in
// flight is dropped with no result. A start during a ray drops the old ray.
// Distances are unsigned Q(32-F).F with all ones meaning infinity;
// max_distance (APB address 0) is unsigned Q8.8.
// ----------------------------------------------------------------------------
module voxel_ray_traversal_core #(
    parameter int DIST_FRAC_BITS = vrt_pkg::DIST_FRAC_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // APB configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [vrt_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    // input stream
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // origin_x[23:0], origin_y[47:24], origin_z[71:48], dir_x[87:72],
    // dir_y[103:88], dir_z[119:104], cell_class[121:120], zero pad[127:122]
    input  logic [127:0]                 s_tdata,
    // func[0]
    input  logic [0:0]                   s_tuser,
    // result stream
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // cell_x[15:0], cell_y[31:16], cell_z[47:32], normal_x[49:48],
    // normal_y[51:50], normal_z[53:52], zero pad[55:54]
    output logic [55:0]                  m_tdata,
    // status[1:0]
    output logic [1:0]                   m_tuser
);

    localparam int DW = DIST_FRAC_BITS + 15;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_DLOAD = 6'b000010,
        S_DWAIT = 6'b000100,
        S_PICK  = 6'b001000,
        S_ADV   = 6'b010000,
        S_EMIT  = 6'b100000
    } state_t;

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [15:0] max_dist_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[2] == vrt_pkg::REG_MAX_DISTANCE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_dist_reg <= vrt_pkg::MAX_DIST_RESET;
        end else if (cfg_wr) begin
            max_dist_reg <= pwdata[15:0];
        end
    end

    assign prdata = (paddr[2] == vrt_pkg::REG_MAX_DISTANCE) ? {16'd0, max_dist_reg} : 32'd0;

    // ------------------------------------------------------------------
    // Input field unpack
    // ------------------------------------------------------------------
    logic [23:0] in_origin [3];
    logic [15:0] in_dir [3];
    logic [1:0]  in_class;
    logic [15:0] in_mag [3];
    logic [8:0]  in_num [3];
    logic [1:0]  in_step [3];

    assign in_origin[0] = s_tdata[23:0];
    assign in_origin[1] = s_tdata[47:24];
    assign in_origin[2] = s_tdata[71:48];
    assign in_dir[0]    = s_tdata[87:72];
    assign in_dir[1]    = s_tdata[103:88];
    assign in_dir[2]    = s_tdata[119:104];
    assign in_class     = s_tdata[121:120];

    // magnitude, first-boundary numerator (in 1/256 cell) and step per axis
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            in_mag[i] = in_dir[i][15] ? (~in_dir[i] + 16'd1) : in_dir[i];
            if (in_dir[i] == 16'd0) begin
                in_step[i] = vrt_pkg::STEP_NONE;
                in_num[i]  = {1'b0, in_origin[i][7:0]};
            end else if (in_dir[i][15]) begin
                in_step[i] = vrt_pkg::STEP_NEG;
                in_num[i]  = {1'b0, in_origin[i][7:0]};
            end else begin
                in_step[i] = vrt_pkg::STEP_POS;
                // an origin on a boundary sees a full cell ahead
                in_num[i]  = (in_origin[i][7:0] == 8'd0) ? 9'd256
                             : 9'd256 - {1'b0, in_origin[i][7:0]};
            end
        end
    end

    // ------------------------------------------------------------------
    // Ray state
    // ------------------------------------------------------------------
    state_t      state_reg, state_next;
    logic        active_reg, active_next;
    logic [1:0]  ax_reg, ax_next;
    logic        op_reg, op_next;
    logic [1:0]  status_reg, status_next;
    logic [15:0] cell_reg [3];
    logic [15:0] cell_next [3];
    logic [1:0]  step_reg [3];
    logic [1:0]  step_next [3];
    logic [1:0]  normal_reg [3];
    logic [1:0]  normal_next [3];
    logic [31:0] nb_reg [3];
    logic [31:0] nb_next [3];
    logic [31:0] delta_reg [3];
    logic [31:0] delta_next [3];
    logic [15:0] mag_reg [3];
    logic [15:0] mag_next [3];
    logic [8:0]  num_reg [3];
    logic [8:0]  num_next [3];

    logic [55:0] m_data_reg, m_data_next;
    logic [1:0]  m_user_reg, m_user_next;
    logic        m_valid_reg, m_valid_next;

    // divider hookup
    logic              div_start;
    logic [DW-1:0]     div_dividend;
    logic [15:0]       div_divisor;
    vrt_pkg::div_res_t div_res;

    vrt_div #(
        .DW (DW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .res      (div_res)
    );

    // delta = 2^(14+F)/|d|; first boundary = num * 2^(6+F)/|d|
    assign div_dividend = op_reg ? (DW'(num_reg[ax_reg]) << (DIST_FRAC_BITS + 6))
                                 : (DW'(1) << (DIST_FRAC_BITS + 14));
    assign div_divisor  = mag_reg[ax_reg];

    // nearest boundary, strict-less: x if below y and z, else y if below z, else z
    logic [1:0]  pick_ax;
    logic [32:0] adv_sum;
    logic [31:0] reach_lim;
    logic        beyond;
    logic        out_free;

    always_comb begin
        if (nb_reg[0] < nb_reg[1]) begin
            pick_ax = (nb_reg[0] < nb_reg[2]) ? 2'd0 : 2'd2;
        end else begin
            pick_ax = (nb_reg[1] < nb_reg[2]) ? 2'd1 : 2'd2;
        end
    end

    // in S_ADV ax_reg holds the axis picked the cycle before; the boundary
    // it crosses is the new ray parameter
    assign adv_sum   = {1'b0, nb_reg[ax_reg]} + {1'b0, delta_reg[ax_reg]};
    assign reach_lim = 32'(max_dist_reg) << (DIST_FRAC_BITS - 8);
    assign beyond    = (nb_reg[ax_reg] == '1) || (nb_reg[ax_reg] > reach_lim);
    assign out_free  = !m_valid_reg || m_tready;

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next   = state_reg;
        active_next  = active_reg;
        ax_next      = ax_reg;
        op_next      = op_reg;
        status_next  = status_reg;
        cell_next    = cell_reg;
        step_next    = step_reg;
        normal_next  = normal_reg;
        nb_next      = nb_reg;
        delta_next   = delta_reg;
        mag_next     = mag_reg;
        num_next     = num_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        m_valid_next = m_valid_reg && !m_tready;
        div_start    = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser[0] == vrt_pkg::FUNC_START) begin
                        for (int i = 0; i < 3; i++) begin
                            cell_next[i]   = in_origin[i][23:8];
                            step_next[i]   = in_step[i];
                            normal_next[i] = 2'b00;
                            mag_next[i]    = in_mag[i];
                            num_next[i]    = in_num[i];
                        end
                        active_next = 1'b1;
                        ax_next     = 2'd0;
                        op_next     = 1'b0;
                        state_next  = S_DLOAD;
                    end else if (active_reg) begin
                        priority if (in_class == vrt_pkg::CLS_HIT) begin
                            active_next = 1'b0;
                            status_next = vrt_pkg::STATUS_HIT;
                            state_next  = S_EMIT;
                        end else if (in_class == vrt_pkg::CLS_PASS) begin
                            state_next  = S_PICK;
                        end else begin
                            // block march, and the unused class too
                            active_next = 1'b0;
                            status_next = vrt_pkg::STATUS_BLOCKED;
                            state_next  = S_EMIT;
                        end
                    end
                    // a report with no ray in flight is dropped
                end
            end

            S_DLOAD: begin
                if (mag_reg[ax_reg] == 16'd0) begin
                    // zero direction: never crosses a boundary on this axis
                    delta_next[ax_reg] = '1;
                    nb_next[ax_reg]    = '1;
                    if (ax_reg == 2'd2) begin
                        status_next = vrt_pkg::STATUS_QUERY;
                        state_next  = S_EMIT;
                    end else begin
                        ax_next = ax_reg + 2'd1;
                    end
                end else begin
                    div_start  = 1'b1;
                    state_next = S_DWAIT;
                end
            end

            S_DWAIT: begin
                if (div_res.done) begin
                    if (!op_reg) begin
                        delta_next[ax_reg] = div_res.quotient;
                        op_next            = 1'b1;
                        state_next         = S_DLOAD;
                    end else begin
                        nb_next[ax_reg] = div_res.quotient;
                        op_next         = 1'b0;
                        if (ax_reg == 2'd2) begin
                            status_next = vrt_pkg::STATUS_QUERY;
                            state_next  = S_EMIT;
                        end else begin
                            ax_next    = ax_reg + 2'd1;
                            state_next = S_DLOAD;
                        end
                    end
                end
            end

            S_PICK: begin
                ax_next    = pick_ax;
                state_next = S_ADV;
            end

            S_ADV: begin
                cell_next[ax_reg] = cell_reg[ax_reg] + {{14{step_reg[ax_reg][1]}}, step_reg[ax_reg]};
                nb_next[ax_reg]   = adv_sum[32] ? '1 : adv_sum[31:0];
                for (int i = 0; i < 3; i++) begin
                    normal_next[i] = 2'b00;
                end
                normal_next[ax_reg] = 2'b00 - step_reg[ax_reg];
                if (beyond) begin
                    active_next = 1'b0;
                    status_next = vrt_pkg::STATUS_MISS;
                end else begin
                    status_next = vrt_pkg::STATUS_QUERY;
                end
                state_next = S_EMIT;
            end

            S_EMIT: begin
                // hold until the output register frees up
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_user_next  = status_reg;
                    unique case (status_reg)
                        vrt_pkg::STATUS_MISS: begin
                            m_data_next = '0;
                        end
                        vrt_pkg::STATUS_HIT: begin
                            m_data_next = {2'b00, normal_reg[2], normal_reg[1], normal_reg[0],
                                           cell_reg[2], cell_reg[1], cell_reg[0]};
                        end
                        default: begin
                            m_data_next = {8'd0, cell_reg[2], cell_reg[1], cell_reg[0]};
                        end
                    endcase
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            active_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            ax_reg      <= 2'd0;
            op_reg      <= 1'b0;
        end else begin
            state_reg   <= state_next;
            active_reg  <= active_next;
            m_valid_reg <= m_valid_next;
            ax_reg      <= ax_next;
            op_reg      <= op_next;
        end
        status_reg <= status_next;
        cell_reg   <= cell_next;
        step_reg   <= step_next;
        normal_reg <= normal_next;
        nb_reg     <= nb_next;
        delta_reg  <= delta_next;
        mag_reg    <= mag_next;
        num_reg    <= num_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule
